// ===== hdl/single_head_attention_softmax_assert.svh =====
// Assertion macros for the attention softmax block.
// Expects clk_i and rst_ni in the scope of each use; no other dependencies.
`ifndef SINGLE_HEAD_ATTENTION_SOFTMAX_ASSERT_SVH
`define SINGLE_HEAD_ATTENTION_SOFTMAX_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication.
`define SHA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define SHA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SHA_ASSERT_IMP(lbl, ante, cons, msg)
`define SHA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/sha_pkg.sv =====
// Shared types, codes and helpers for the attention softmax block.
// No dependencies.
`timescale 1ns / 1ps

package sha_pkg;

  typedef enum logic [2:0] {
    MODE_CLEAR   = 3'd0,
    MODE_QUERY   = 3'd1,
    MODE_KEY     = 3'd2,
    MODE_SOFTMAX = 3'd3,
    MODE_VALUE   = 3'd4,
    MODE_READ    = 3'd5
  } mode_e;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_RANGE    = 2'd1;
  localparam logic [1:0] STAT_NO_PROBS = 2'd2;

  localparam logic CFG_SCORE_SCALE = 1'b0;
  localparam logic CFG_HEAD_DIM    = 1'b1;

  localparam logic [15:0] SCALE_RESET = 16'd8192;
  localparam logic [8:0]  HDIM_RESET  = 9'd128;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_CLEAR,
    S_KEY_MUL,
    S_KEY_WR,
    S_VAL_MUL,
    S_VAL_WR,
    S_RD_OUT,
    S_SM_RD,
    S_SM_ABS,
    S_SM_MUL,
    S_SM_SCL,
    S_SM_CMP,
    S_SM_EXP,
    S_SM_DRD,
    S_SM_DST,
    S_SM_DWAIT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]         mode;
    logic [9:0]         token;
    logic [7:0]         dim;
    logic signed [15:0] elem_value;
    logic [10:0]        ctx_len;
  } in_t;

  typedef struct packed {
    logic signed [15:0] out_value;
    logic [1:0]         status;
  } out_t;

  // Clamp a 49-bit sum into the 48-bit accumulator range.
  function automatic logic signed [47:0] sat48(input logic signed [48:0] x);
    logic signed [47:0] r;
    if (x[48] != x[47]) begin
      r = x[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      r = x[47:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/sha_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sha_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/sha_exp_rom.sv =====
// Constant exp(-k/64) table in unsigned Q1.16 with registered read.
// No dependencies; the table is built at elaboration.
`timescale 1ns / 1ps

module sha_exp_rom #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  output logic [16:0]              data_o
);

  typedef logic [16:0] tab_t [DEPTH];

  // t0 = 2^31, each step multiplies by exp(-1/64) in Q0.32 with rounding.
  function automatic tab_t build_tab();
    tab_t        r;
    logic [63:0] t;
    t = 64'h8000_0000;
    for (int i = 0; i < DEPTH; i++) begin
      r[i] = 17'((t + 64'd16384) >> 15);
      t    = (t * 64'd4228380000 + 64'h8000_0000) >> 32;
    end
    return r;
  endfunction

  localparam tab_t Tab = build_tab();

  logic [16:0] data_q;

  always_ff @(posedge clk_i) begin
    if (32'(addr_i) < 32'(DEPTH)) begin
      data_q <= Tab[addr_i];
    end else begin
      data_q <= '0;
    end
  end

  assign data_o = data_q;

endmodule

// ===== hdl/sha_div.sv =====
// Iterative divider: (num * 2^16 + den / 2) / den, one quotient bit per cycle.
// No dependencies. Quotient must fit 17 bits (num <= den).
`timescale 1ns / 1ps

module sha_div #(
  parameter int SUM_W = 27
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [16:0]      num_i,
  input  logic [SUM_W-1:0] den_i,
  output logic             done_o,
  output logic [16:0]      quot_o
);

  localparam int NumW = 34;
  localparam int RemW = SUM_W + 1;

  logic [NumW-1:0]  dividend;
  logic [RemW-1:0]  trial;
  logic             fits;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [16:0]      low_q, low_d;
  logic [SUM_W-1:0] den_q, den_d;
  logic [4:0]       cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             done_q, done_d;

  assign dividend = NumW'({num_i, 16'd0}) + NumW'(den_i >> 1);
  assign trial    = {rem_q[SUM_W-1:0], low_q[16]};
  assign fits     = trial >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    low_d  = low_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      // upper part is already below den, so 17 steps give the quotient
      rem_d = RemW'(dividend >> 17);
      low_d = dividend[16:0];
      den_d = den_i;
      cnt_d = 5'd17;
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = fits ? (trial - {1'b0, den_q}) : trial;
      low_d = {low_q[15:0], fits};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = low_q;

endmodule

// ===== hdl/single_head_attention_softmax.sv =====
// Top level of the single-head attention softmax block.
// Depends on sha_pkg, sha_ram, sha_exp_rom, sha_div and the assertion header.
`timescale 1ns / 1ps
`include "single_head_attention_softmax_assert.svh"

// One attention head for one sequence in fixed point. Words arrive on a
// valid/ready channel and each gives exactly one result word (out_value,
// status). Commands: clear zeroes logits and output accumulators; query
// stores an element per dimension; key adds query*key into its token's
// logit; softmax turns the logits of the first tokens of the context into
// probabilities; value adds probability*value into the output accumulators;
// read returns the rounded, saturated output. Items are handled one at a
// time through a small sequencer around four RAMs (query, logit, probability,
// output), each with one write and one registered read port; every command
// finishes its write-back before the next word is taken, so no forwarding is
// needed. A finished result waits in the output register while the next word
// comes in. Softmax walks the logit RAM twice (for the maximum, then for
// the exp table and sum) and then divides each probability with a
// one-bit-per-cycle divider, zero-filling the rest of the store. A stalled
// result channel holds the sequencer until the output register is free.
// After reset a clearing pass runs with in_ready_o low; configuration
// writes are taken at any time and must come only when idle.
module single_head_attention_softmax #(
  parameter int HEAD_DIM_MAX    = 256,
  parameter int MAX_TOKENS      = 1024,
  parameter int EXP_TABLE_DEPTH = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sha_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sha_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [15:0]   cfg_data_i
);

  localparam int TW   = $clog2(MAX_TOKENS);
  localparam int DW   = $clog2(HEAD_DIM_MAX);
  localparam int EW   = $clog2(EXP_TABLE_DEPTH);
  localparam int SW   = TW + 17;
  localparam int NCLR = (MAX_TOKENS > HEAD_DIM_MAX) ? MAX_TOKENS : HEAD_DIM_MAX;
  localparam int CW   = $clog2(NCLR) + 1;

  sha_pkg::state_e state_q, state_d;

  // control
  logic          out_vld_q, out_vld_d;
  logic [15:0]   scale_q;
  logic [8:0]    hdu_q;
  logic          rdy_q, rdy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          max_pass_q, max_pass_d;

  // payload
  sha_pkg::in_t       in_q, in_d;
  sha_pkg::out_t      res_q, res_d;
  sha_pkg::out_t      out_q, out_d;
  logic [CW-1:0]      len_q, len_d;
  logic               neg_q, neg_d;
  logic [47:0]        mag_q, mag_d;
  logic [47:0]        hi_q, hi_d;
  logic [31:0]        lo_q, lo_d;
  logic signed [47:0] scaled_q, scaled_d;
  logic signed [47:0] mx_q, mx_d;
  logic               oor_q, oor_d;
  logic [SW-1:0]      sum_q, sum_d;
  logic signed [47:0] acc_q, acc_d;
  logic signed [33:0] prod_q, prod_d;

  // memory ports
  logic          q_we;
  logic [DW-1:0] q_waddr, q_raddr;
  logic [15:0]   q_rdata;
  logic          lg_we;
  logic [TW-1:0] lg_waddr, lg_raddr;
  logic [47:0]   lg_wdata, lg_rdata;
  logic          pb_we;
  logic [TW-1:0] pb_waddr, pb_raddr;
  logic [16:0]   pb_wdata, pb_rdata;
  logic          oa_we;
  logic [DW-1:0] oa_waddr, oa_raddr;
  logic [47:0]   oa_wdata, oa_rdata;

  logic [EW-1:0] rom_addr;
  logic [16:0]   rom_data;
  logic          div_start, div_done;
  logic [16:0]   div_quot;

  logic [8:0]    dims;
  logic          dim_ok, tok_ok, len_ok;
  logic [48:0]   diff;

  // Effective head dimension: multiple of 16, clamped to 16..HEAD_DIM_MAX.
  always_comb begin
    dims = hdu_q & 9'h1F0;
    if (dims < 9'd16) begin
      dims = 9'd16;
    end
    if (32'(dims) > 32'(HEAD_DIM_MAX)) begin
      dims = 9'(HEAD_DIM_MAX);
    end
  end

  assign dim_ok = {1'b0, in_q.dim} < dims;
  assign tok_ok = 32'(in_q.token) < 32'(MAX_TOKENS);
  assign len_ok = (in_q.ctx_len != 11'd0) &&
                  (32'(in_q.ctx_len) <= 32'(MAX_TOKENS));

  // Distance below the maximum, in Q16.16; the table steps by 1/64.
  assign diff     = $unsigned({mx_q[47], mx_q}) - $unsigned({scaled_q[47], scaled_q});
  assign rom_addr = EW'(diff >> 10);

  assign in_ready_o = (state_q == sha_pkg::S_IDLE);

  always_comb begin
    logic signed [31:0] kprod;
    logic signed [33:0] vprod;
    logic signed [48:0] rnd;
    logic signed [32:0] shr;
    logic [47:0]        r48;
    logic [16:0]        entry;

    state_d    = state_q;
    out_vld_d  = out_vld_q & ~out_ready_i;
    rdy_d      = rdy_q;
    cnt_d      = cnt_q;
    max_pass_d = max_pass_q;
    in_d       = in_q;
    res_d      = res_q;
    out_d      = out_q;
    len_d      = len_q;
    neg_d      = neg_q;
    mag_d      = mag_q;
    hi_d       = hi_q;
    lo_d       = lo_q;
    scaled_d   = scaled_q;
    mx_d       = mx_q;
    oor_d      = oor_q;
    sum_d      = sum_q;
    acc_d      = acc_q;
    prod_d     = prod_q;

    q_we      = 1'b0;
    q_waddr   = DW'(in_q.dim);
    q_raddr   = DW'(in_q.dim);
    lg_we     = 1'b0;
    lg_waddr  = TW'(in_q.token);
    lg_wdata  = '0;
    lg_raddr  = TW'(in_q.token);
    pb_we     = 1'b0;
    pb_waddr  = cnt_q[TW-1:0];
    pb_wdata  = '0;
    pb_raddr  = TW'(in_q.token);
    oa_we     = 1'b0;
    oa_waddr  = DW'(in_q.dim);
    oa_wdata  = '0;
    oa_raddr  = DW'(in_q.dim);
    div_start = 1'b0;

    kprod = $signed(q_rdata) * in_q.elem_value;
    vprod = $signed({1'b0, pb_rdata}) * in_q.elem_value;
    rnd   = $signed({oa_rdata[47], oa_rdata}) + 49'sd32768;
    shr   = rnd[48:16];
    r48   = hi_q + 48'(lo_q >> 16);
    entry = oor_q ? 17'd0 : rom_data;

    case (state_q)
      // Zero the logit and output stores, one entry of each a cycle.
      sha_pkg::S_INIT, sha_pkg::S_CLEAR: begin
        lg_we    = 32'(cnt_q) < 32'(MAX_TOKENS);
        lg_waddr = cnt_q[TW-1:0];
        lg_wdata = '0;
        oa_we    = 32'(cnt_q) < 32'(HEAD_DIM_MAX);
        oa_waddr = DW'(cnt_q);
        oa_wdata = '0;
        rdy_d    = 1'b0;
        cnt_d    = cnt_q + CW'(1);
        if (cnt_q == CW'(NCLR - 1)) begin
          cnt_d   = '0;
          state_d = (state_q == sha_pkg::S_INIT) ? sha_pkg::S_IDLE : sha_pkg::S_DONE;
        end
      end
      sha_pkg::S_IDLE: begin
        if (in_valid_i) begin
          in_d    = in_data_i;
          state_d = sha_pkg::S_DECODE;
        end
      end
      sha_pkg::S_DECODE: begin
        res_d.out_value = '0;
        res_d.status    = sha_pkg::STAT_OK;
        state_d         = sha_pkg::S_DONE;
        case (sha_pkg::mode_e'(in_q.mode))
          sha_pkg::MODE_CLEAR: begin
            cnt_d   = '0;
            state_d = sha_pkg::S_CLEAR;
          end
          sha_pkg::MODE_QUERY: begin
            if (!dim_ok) begin
              res_d.status = sha_pkg::STAT_RANGE;
            end else begin
              q_we = 1'b1;
            end
          end
          sha_pkg::MODE_KEY: begin
            if (!dim_ok || !tok_ok) begin
              res_d.status = sha_pkg::STAT_RANGE;
            end else begin
              state_d = sha_pkg::S_KEY_MUL;
            end
          end
          sha_pkg::MODE_SOFTMAX: begin
            if (!len_ok) begin
              res_d.status = sha_pkg::STAT_RANGE;
            end else begin
              len_d      = CW'(in_q.ctx_len);
              cnt_d      = '0;
              max_pass_d = 1'b1;
              sum_d      = '0;
              state_d    = sha_pkg::S_SM_RD;
            end
          end
          sha_pkg::MODE_VALUE: begin
            if (!dim_ok || !tok_ok) begin
              res_d.status = sha_pkg::STAT_RANGE;
            end else if (!rdy_q) begin
              res_d.status = sha_pkg::STAT_NO_PROBS;
            end else begin
              state_d = sha_pkg::S_VAL_MUL;
            end
          end
          sha_pkg::MODE_READ: begin
            if (!dim_ok) begin
              res_d.status = sha_pkg::STAT_RANGE;
            end else if (!rdy_q) begin
              res_d.status = sha_pkg::STAT_NO_PROBS;
            end else begin
              state_d = sha_pkg::S_RD_OUT;
            end
          end
          default: begin
            res_d.status = sha_pkg::STAT_RANGE;
          end
        endcase
      end
      sha_pkg::S_KEY_MUL: begin
        prod_d  = 34'(kprod);
        acc_d   = $signed(lg_rdata);
        state_d = sha_pkg::S_KEY_WR;
      end
      sha_pkg::S_KEY_WR: begin
        lg_we   = 1'b1;
        lg_wdata = sha_pkg::sat48($signed({acc_q[47], acc_q}) + 49'(prod_q));
        rdy_d   = 1'b0;
        state_d = sha_pkg::S_DONE;
      end
      sha_pkg::S_VAL_MUL: begin
        prod_d  = vprod;
        acc_d   = $signed(oa_rdata);
        state_d = sha_pkg::S_VAL_WR;
      end
      sha_pkg::S_VAL_WR: begin
        oa_we    = 1'b1;
        oa_wdata = sha_pkg::sat48($signed({acc_q[47], acc_q}) + 49'(prod_q));
        state_d  = sha_pkg::S_DONE;
      end
      sha_pkg::S_RD_OUT: begin
        if (shr > 33'sd32767) begin
          res_d.out_value = 16'sh7FFF;
        end else if (shr < -33'sd32768) begin
          res_d.out_value = 16'sh8000;
        end else begin
          res_d.out_value = shr[15:0];
        end
        state_d = sha_pkg::S_DONE;
      end
      // Scale each logit: fetch, magnitude, split multiply, sum and sign.
      sha_pkg::S_SM_RD: begin
        lg_raddr = cnt_q[TW-1:0];
        state_d  = sha_pkg::S_SM_ABS;
      end
      sha_pkg::S_SM_ABS: begin
        neg_d   = lg_rdata[47];
        mag_d   = lg_rdata[47] ? (~lg_rdata + 48'd1) : lg_rdata;
        state_d = sha_pkg::S_SM_MUL;
      end
      sha_pkg::S_SM_MUL: begin
        hi_d    = 48'(mag_q[47:16] * scale_q);
        lo_d    = mag_q[15:0] * scale_q;
        state_d = sha_pkg::S_SM_SCL;
      end
      sha_pkg::S_SM_SCL: begin
        scaled_d = neg_q ? $signed(~r48 + 48'd1) : $signed(r48);
        state_d  = sha_pkg::S_SM_CMP;
      end
      sha_pkg::S_SM_CMP: begin
        if (max_pass_q) begin
          if (cnt_q == '0 || scaled_q > mx_q) begin
            mx_d = scaled_q;
          end
          state_d = sha_pkg::S_SM_RD;
          if (cnt_q == len_q - CW'(1)) begin
            cnt_d      = '0;
            max_pass_d = 1'b0;
          end else begin
            cnt_d = cnt_q + CW'(1);
          end
        end else begin
          // table address is presented now, data arrives next cycle
          oor_d   = 39'(diff >> 10) >= 39'(EXP_TABLE_DEPTH);
          state_d = sha_pkg::S_SM_EXP;
        end
      end
      sha_pkg::S_SM_EXP: begin
        pb_we    = 1'b1;
        pb_wdata = entry;
        sum_d    = sum_q + SW'(entry);
        if (cnt_q == len_q - CW'(1)) begin
          cnt_d   = '0;
          state_d = sha_pkg::S_SM_DRD;
        end else begin
          cnt_d   = cnt_q + CW'(1);
          state_d = sha_pkg::S_SM_RD;
        end
      end
      // Normalise inside the context, zero-fill the rest of the store.
      sha_pkg::S_SM_DRD: begin
        pb_raddr = cnt_q[TW-1:0];
        if (cnt_q < len_q) begin
          state_d = sha_pkg::S_SM_DST;
        end else begin
          pb_we    = 1'b1;
          pb_wdata = '0;
          if (cnt_q == CW'(MAX_TOKENS - 1)) begin
            rdy_d   = 1'b1;
            state_d = sha_pkg::S_DONE;
          end else begin
            cnt_d = cnt_q + CW'(1);
          end
        end
      end
      sha_pkg::S_SM_DST: begin
        div_start = 1'b1;
        state_d   = sha_pkg::S_SM_DWAIT;
      end
      sha_pkg::S_SM_DWAIT: begin
        if (div_done) begin
          pb_we    = 1'b1;
          pb_wdata = div_quot;
          if (cnt_q == CW'(MAX_TOKENS - 1)) begin
            rdy_d   = 1'b1;
            state_d = sha_pkg::S_DONE;
          end else begin
            cnt_d   = cnt_q + CW'(1);
            state_d = sha_pkg::S_SM_DRD;
          end
        end
      end
      // Hold the result until the output register is free.
      sha_pkg::S_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = sha_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = sha_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha_pkg::S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      rdy_q      <= 1'b0;
      cnt_q      <= '0;
      max_pass_q <= 1'b0;
      scale_q    <= sha_pkg::SCALE_RESET;
      hdu_q      <= sha_pkg::HDIM_RESET;
    end else begin
      out_vld_q  <= out_vld_d;
      rdy_q      <= rdy_d;
      cnt_q      <= cnt_d;
      max_pass_q <= max_pass_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sha_pkg::CFG_SCORE_SCALE: scale_q <= cfg_data_i;
          sha_pkg::CFG_HEAD_DIM:    hdu_q   <= cfg_data_i[8:0];
          default:                  scale_q <= scale_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    in_q     <= in_d;
    res_q    <= res_d;
    out_q    <= out_d;
    len_q    <= len_d;
    neg_q    <= neg_d;
    mag_q    <= mag_d;
    hi_q     <= hi_d;
    lo_q     <= lo_d;
    scaled_q <= scaled_d;
    mx_q     <= mx_d;
    oor_q    <= oor_d;
    sum_q    <= sum_d;
    acc_q    <= acc_d;
    prod_q   <= prod_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  sha_ram #(.WIDTH(16), .DEPTH(HEAD_DIM_MAX)) u_query_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (in_q.elem_value),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  sha_ram #(.WIDTH(48), .DEPTH(MAX_TOKENS)) u_logit_ram (
    .clk_i   (clk_i),
    .we_i    (lg_we),
    .waddr_i (lg_waddr),
    .wdata_i (lg_wdata),
    .raddr_i (lg_raddr),
    .rdata_o (lg_rdata)
  );

  sha_ram #(.WIDTH(17), .DEPTH(MAX_TOKENS)) u_prob_ram (
    .clk_i   (clk_i),
    .we_i    (pb_we),
    .waddr_i (pb_waddr),
    .wdata_i (pb_wdata),
    .raddr_i (pb_raddr),
    .rdata_o (pb_rdata)
  );

  sha_ram #(.WIDTH(48), .DEPTH(HEAD_DIM_MAX)) u_out_ram (
    .clk_i   (clk_i),
    .we_i    (oa_we),
    .waddr_i (oa_waddr),
    .wdata_i (oa_wdata),
    .raddr_i (oa_raddr),
    .rdata_o (oa_rdata)
  );

  sha_exp_rom #(.DEPTH(EXP_TABLE_DEPTH)) u_exp_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  sha_div #(.SUM_W(SW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (pb_rdata),
    .den_i   (sum_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Divider finishes only while the sequencer waits for it.
  `SHA_ASSERT_IMP(a_div_ctx, div_done, state_q == sha_pkg::S_SM_DWAIT, "divider done out of place")
  // Probabilities become ready only at the end of the normalise pass.
  `SHA_ASSERT_IMP(a_rdy_set, $rose(rdy_q), $past(state_q) == sha_pkg::S_SM_DRD || $past(state_q) == sha_pkg::S_SM_DWAIT, "probs ready set outside softmax")
  // A rejected word carries a zero output.
  `SHA_ASSERT_IMP(a_err_zero, out_vld_q && out_q.status != sha_pkg::STAT_OK, out_q.out_value == 16'sd0, "nonzero output on error status")
  // A started division is always waited for by the sequencer.
  `SHA_ASSERT_NXT(a_div_start, div_start, state_q == sha_pkg::S_SM_DWAIT, "divider start not followed by wait")

endmodule
